>>> sv/sem_pkg.sv
// Shared types, widths and codes for the RGB Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

  // Longest supported image row and the widths that follow from it.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_W     = COL_W + 1;

  // Fixed field widths of the configuration registers.
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int ROW_W          = FRAME_HEIGHT_W + 1;

  // Pixel and arithmetic widths.
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int GRAD_W     = CH_W + 3;
  localparam int SQ_W       = 2 * GRAD_W - 2;
  localparam int SUM_W      = SQ_W + 1;
  localparam int RAD_W      = 2 * CH_W;
  localparam int REM_W      = CH_W + 3;
  localparam int ROOT_STEPS = CH_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  // Saturation: a rounded root above the channel maximum starts at this sum.
  localparam int                 CH_MAX_INT = (1 << CH_W) - 1;
  localparam logic [CH_W-1:0]    CH_MAX     = CH_W'(CH_MAX_INT);
  localparam logic [SUM_W-1:0]   SAT_LIMIT  =
    SUM_W'(CH_MAX_INT * CH_MAX_INT + CH_MAX_INT + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 8'd0,
    REG_FRAME_HEIGHT = 8'd1
  } cfg_reg_e;

  // Input item kinds.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  // Top level sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ROOT
  } st_e;

  // Magnitude unit sequencer.
  typedef enum logic [2:0] {
    MST_IDLE,
    MST_SQUARE,
    MST_SUM,
    MST_ITER,
    MST_DONE
  } mst_e;

  // Request to a magnitude unit and its answer.
  typedef struct packed {
    logic  start;
    grad_t gx;
    grad_t gy;
  } mag_req_t;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] mag;
  } mag_rsp_t;

endpackage

`default_nettype wire

>>> sv/sem_line_ram.sv
// Simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module sem_line_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> sv/sem_mag.sv
// Gradient magnitude unit: squares, sums and takes a rounded, saturated root.
`timescale 1ns / 1ps
`default_nettype none

module sem_mag (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sem_pkg::mag_req_t req_i,
  output sem_pkg::mag_rsp_t     rsp_o
);

  sem_pkg::mst_e state_q, state_d;

  sem_pkg::grad_t                   gx_q, gy_q;
  logic [sem_pkg::SQ_W-1:0]         sqx_q, sqy_q;
  logic [sem_pkg::RAD_W-1:0]        rad_q;
  logic                             sat_q;
  logic [sem_pkg::CH_W-1:0]         root_q, root_d;
  logic [sem_pkg::REM_W-1:0]        rem_q, rem_d;
  logic [sem_pkg::STEP_W-1:0]       step_q;

  logic signed [2*sem_pkg::GRAD_W-1:0] prod_x, prod_y;
  logic [sem_pkg::SUM_W-1:0]           sum;
  logic [sem_pkg::REM_W-1:0]           rem_sh, trial;
  logic                                start;

  assign start = req_i.start && (state_q == sem_pkg::MST_IDLE ||
                                 state_q == sem_pkg::MST_DONE);

  // Squares and their sum.
  assign prod_x = gx_q * gx_q;
  assign prod_y = gy_q * gy_q;
  assign sum    = sem_pkg::SUM_W'(sqx_q) + sem_pkg::SUM_W'(sqy_q);

  // One restoring root step: bring down two radicand bits, try the next root bit.
  always_comb begin
    rem_sh = {rem_q[sem_pkg::REM_W-3:0], rad_q[sem_pkg::RAD_W-1 -: 2]};
    trial  = sem_pkg::REM_W'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[sem_pkg::CH_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[sem_pkg::CH_W-2:0], 1'b0};
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::MST_IDLE, sem_pkg::MST_DONE: begin
        if (start) begin
          state_d = sem_pkg::MST_SQUARE;
        end
      end
      sem_pkg::MST_SQUARE: state_d = sem_pkg::MST_SUM;
      sem_pkg::MST_SUM:    state_d = sem_pkg::MST_ITER;
      sem_pkg::MST_ITER: begin
        if (step_q == '0) begin
          state_d = sem_pkg::MST_DONE;
        end
      end
      default: state_d = sem_pkg::MST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::MST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start) begin
      gx_q <= req_i.gx;
      gy_q <= req_i.gy;
    end
    if (state_q == sem_pkg::MST_SQUARE) begin
      sqx_q <= prod_x[sem_pkg::SQ_W-1:0];
      sqy_q <= prod_y[sem_pkg::SQ_W-1:0];
    end
    if (state_q == sem_pkg::MST_SUM) begin
      rad_q  <= sum[sem_pkg::RAD_W-1:0];
      sat_q  <= sum >= sem_pkg::SAT_LIMIT;
      root_q <= '0;
      rem_q  <= '0;
      step_q <= sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1);
    end
    if (state_q == sem_pkg::MST_ITER) begin
      rad_q  <= {rad_q[sem_pkg::RAD_W-3:0], 2'b00};
      root_q <= root_d;
      rem_q  <= rem_d;
      step_q <= step_q - sem_pkg::STEP_W'(1);
    end
  end

  // Round half up: the remainder above the floor root means the next integer.
  always_comb begin
    rsp_o.valid = (state_q == sem_pkg::MST_DONE);
    if (sat_q) begin
      rsp_o.mag = sem_pkg::CH_MAX;
    end else if (rem_q > sem_pkg::REM_W'(root_q)) begin
      rsp_o.mag = root_q + sem_pkg::CH_W'(1);
    end else begin
      rsp_o.mag = root_q;
    end
  end

endmodule

`default_nettype wire

>>> sv/sobel_edge_magnitude_rgb.sv
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
//
// Usage: configure frame width (register 0) and height (register 1) on the
// configuration channel while the block is idle; each write restarts the
// frame. Then send the frame's pixels in raster order on the input channel
// with mode 0, followed by flush words with mode 1. The result for a pixel
// appears once the raster position one row and one pixel further has been
// reached, so width+1 flush words drain a frame; frame_last marks the final
// result. A flush word during the frame and a pixel during the drain are
// taken and dropped.
// Flow: each taken word reads its entry of the shared line store, and a pixel
// then writes the same entry back. A word that yields a result keeps the
// block busy until the eight-step root unit is done and its result is loaded;
// a word without result frees it sooner, and a dropped word is only accepted.
// The result sits in an output register, so the next word is taken while it
// waits; a stalled receiver holds back the next result and with it the input.
// Reset: width and height are 1, counters and window are clear, and the line
// store holds nothing valid; its entries are written before they are used.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_rgb (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input pixels and flush words.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           mode_i,
  input  wire logic [sem_pkg::CH_W-1:0]       red_in_i,
  input  wire logic [sem_pkg::CH_W-1:0]       green_in_i,
  input  wire logic [sem_pkg::CH_W-1:0]       blue_in_i,
  // Edge results.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [sem_pkg::CH_W-1:0]       red_edge_o,
  output logic      [sem_pkg::CH_W-1:0]       green_edge_o,
  output logic      [sem_pkg::CH_W-1:0]       blue_edge_o,
  output logic                                frame_last_o,
  // Configuration writes.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sem_pkg::st_e state_q, state_d;

  // Configuration and raster position.
  logic [sem_pkg::WID_W-1:0]          width_q, width_d;
  logic [sem_pkg::FRAME_HEIGHT_W-1:0] height_q, height_d;
  logic [sem_pkg::COL_W-1:0]          ic_q;
  logic [sem_pkg::ROW_W-1:0]          ir_q;

  // Left and middle window columns, rows top to bottom.
  sem_pkg::pix_t win1_q [3];
  sem_pkg::pix_t win2_q [3];

  // Word in flight.
  sem_pkg::pix_t pix_q;
  logic          drain_q;
  logic          last_q;

  // Output register.
  logic                     out_valid_q;
  logic [sem_pkg::CH_W-1:0] red_q, green_q, blue_q;
  logic                     flast_q;

  logic in_acc, cfg_acc, draining, take;
  logic cfg_wr_width, cfg_wr_height;
  logic [sem_pkg::FRAME_WIDTH_W-1:0]  cfg_w;
  logic [sem_pkg::FRAME_HEIGHT_W-1:0] cfg_h;

  logic [2*sem_pkg::PIX_W-1:0] rd_data;
  sem_pkg::pix_t               rd_upper, rd_mid;
  sem_pkg::pix_t               col_new [3];
  sem_pkg::pix_t               col_rgt [3];
  logic                        out_en, last_now, wrap;
  logic [sem_pkg::WID_W-1:0]   ic_inc;
  logic                        ram_wr_en;

  sem_pkg::mag_req_t mag_req [sem_pkg::NUM_CH];
  sem_pkg::mag_rsp_t mag_rsp [sem_pkg::NUM_CH];
  logic              mag_all_valid;
  logic              load_out;

  // Weighted 1-2-1 difference used by both kernels.
  function automatic sem_pkg::grad_t grad121(
    input logic [sem_pkg::CH_W-1:0] n0, n1, n2,
    input logic [sem_pkg::CH_W-1:0] p0, p1, p2
  );
    logic [sem_pkg::GRAD_W-1:0] ps, ns;
    ps = sem_pkg::GRAD_W'(p0) + (sem_pkg::GRAD_W'(p1) << 1) + sem_pkg::GRAD_W'(p2);
    ns = sem_pkg::GRAD_W'(n0) + (sem_pkg::GRAD_W'(n1) << 1) + sem_pkg::GRAD_W'(n2);
    return signed'(ps - ns);
  endfunction

  // Handshakes.
  assign in_ready_o  = (state_q == sem_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // A word is used only when its kind matches the frame phase.
  assign draining = ir_q >= {1'b0, height_q};
  assign take     = in_acc && ((mode_i == sem_pkg::MODE_FLUSH) == draining);

  // Register decode and range limits.
  always_comb begin
    cfg_wr_width  = 1'b0;
    cfg_wr_height = 1'b0;
    unique case (cfg_index_i)
      sem_pkg::REG_FRAME_WIDTH:  cfg_wr_width  = cfg_acc;
      sem_pkg::REG_FRAME_HEIGHT: cfg_wr_height = cfg_acc;
      default: ;
    endcase
    cfg_w = cfg_data_i[sem_pkg::FRAME_WIDTH_W-1:0];
    cfg_h = cfg_data_i[sem_pkg::FRAME_HEIGHT_W-1:0];
    if (cfg_w == '0) begin
      width_d = sem_pkg::WID_W'(1);
    end else if (32'(cfg_w) > 32'(sem_pkg::MAX_WIDTH)) begin
      width_d = sem_pkg::WID_W'(sem_pkg::MAX_WIDTH);
    end else begin
      width_d = sem_pkg::WID_W'(cfg_w);
    end
    height_d = (cfg_h == '0) ? sem_pkg::FRAME_HEIGHT_W'(1) : cfg_h;
  end

  // Line store: upper row in the high half, middle row in the low half.
  // The entry is read when the word is taken and, for a pixel, written back in the
  // next cycle; the next read comes later, so the two never overlap.
  assign ram_wr_en = (state_q == sem_pkg::ST_READ) && !drain_q;

  sem_line_ram #(
    .DATA_W (2 * sem_pkg::PIX_W),
    .DEPTH  (sem_pkg::MAX_WIDTH),
    .ADDR_W (sem_pkg::COL_W)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ic_q),
    .wr_data_i ({rd_mid, pix_q}),
    .rd_en_i   (take),
    .rd_addr_i (ic_q),
    .rd_data_o (rd_data)
  );

  assign rd_upper = rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
  assign rd_mid   = rd_data[sem_pkg::PIX_W-1:0];

  // New window column, with rows outside the frame as zero.
  always_comb begin
    col_new[0] = (ir_q >= sem_pkg::ROW_W'(2)) ? rd_upper : '0;
    col_new[1] = (ir_q >= sem_pkg::ROW_W'(1) && ir_q <= {1'b0, height_q}) ? rd_mid : '0;
    col_new[2] = pix_q;
    for (int r = 0; r < 3; r++) begin
      // At the start of a row the right-hand column lies past the edge.
      col_rgt[r] = (ic_q == '0) ? '0 : col_new[r];
    end
  end

  // Output decision and raster advance.
  always_comb begin
    out_en   = (ir_q >= sem_pkg::ROW_W'(2)) || (ir_q == sem_pkg::ROW_W'(1) && ic_q != '0);
    last_now = (ir_q == {1'b0, height_q} + sem_pkg::ROW_W'(1));
    ic_inc   = sem_pkg::WID_W'(ic_q) + sem_pkg::WID_W'(1);
    wrap     = ic_inc >= width_q;
  end

  // Sobel gradients per channel, fed to the magnitude units.
  always_comb begin
    for (int k = 0; k < sem_pkg::NUM_CH; k++) begin
      mag_req[k].start = (state_q == sem_pkg::ST_READ) && out_en;
      mag_req[k].gx = grad121(win1_q[0][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              win1_q[1][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              win1_q[2][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              col_rgt[0][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              col_rgt[1][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              col_rgt[2][k*sem_pkg::CH_W +: sem_pkg::CH_W]);
      mag_req[k].gy = grad121(win1_q[0][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              win2_q[0][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              col_rgt[0][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              win1_q[2][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              win2_q[2][k*sem_pkg::CH_W +: sem_pkg::CH_W],
                              col_rgt[2][k*sem_pkg::CH_W +: sem_pkg::CH_W]);
    end
  end

  // One magnitude unit per channel; index 0 is blue, 2 is red.
  for (genvar g = 0; g < sem_pkg::NUM_CH; g++) begin : g_mag
    sem_mag u_mag (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (mag_req[g]),
      .rsp_o  (mag_rsp[g])
    );
  end

  assign mag_all_valid = mag_rsp[0].valid & mag_rsp[1].valid & mag_rsp[2].valid;
  assign load_out = (state_q == sem_pkg::ST_ROOT) && mag_all_valid &&
                    (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::ST_IDLE: begin
        if (take) begin
          state_d = sem_pkg::ST_READ;
        end
      end
      sem_pkg::ST_READ: begin
        state_d = out_en ? sem_pkg::ST_ROOT : sem_pkg::ST_IDLE;
      end
      sem_pkg::ST_ROOT: begin
        if (load_out) begin
          state_d = sem_pkg::ST_IDLE;
        end
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration, raster counters and window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WID_W'(1);
      height_q <= sem_pkg::FRAME_HEIGHT_W'(1);
      ic_q     <= '0;
      ir_q     <= '0;
      for (int r = 0; r < 3; r++) begin
        win1_q[r] <= '0;
        win2_q[r] <= '0;
      end
    end else if (cfg_wr_width || cfg_wr_height) begin
      if (cfg_wr_width) begin
        width_q <= width_d;
      end
      if (cfg_wr_height) begin
        height_q <= height_d;
      end
      ic_q <= '0;
      ir_q <= '0;
      for (int r = 0; r < 3; r++) begin
        win1_q[r] <= '0;
        win2_q[r] <= '0;
      end
    end else if (state_q == sem_pkg::ST_READ) begin
      if (last_now) begin
        // Final result of the frame: start over.
        ic_q <= '0;
        ir_q <= '0;
        for (int r = 0; r < 3; r++) begin
          win1_q[r] <= '0;
          win2_q[r] <= '0;
        end
      end else begin
        ic_q <= wrap ? '0 : ic_inc[sem_pkg::COL_W-1:0];
        if (wrap) begin
          ir_q <= ir_q + sem_pkg::ROW_W'(1);
        end
        for (int r = 0; r < 3; r++) begin
          win1_q[r] <= (ic_q == '0) ? '0 : win2_q[r];
          win2_q[r] <= col_new[r];
        end
      end
    end
  end

  // Word in flight; a flush word enters the window as a zero pixel.
  always_ff @(posedge clk_i) begin
    if (take) begin
      pix_q   <= draining ? '0 : {red_in_i, green_in_i, blue_in_i};
      drain_q <= draining;
    end
    if (state_q == sem_pkg::ST_READ) begin
      last_q <= last_now;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      red_q   <= mag_rsp[2].mag;
      green_q <= mag_rsp[1].mag;
      blue_q  <= mag_rsp[0].mag;
      flast_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_edge_o   = red_q;
  assign green_edge_o = green_q;
  assign blue_edge_o  = blue_q;
  assign frame_last_o = flast_q;

endmodule

`default_nettype wire

>>> sv/sem_checker.sv
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sem_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           mode_i,
  input wire logic [sem_pkg::CH_W-1:0]       red_in_i,
  input wire logic [sem_pkg::CH_W-1:0]       green_in_i,
  input wire logic [sem_pkg::CH_W-1:0]       blue_in_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [sem_pkg::CH_W-1:0]       red_edge_o,
  input wire logic [sem_pkg::CH_W-1:0]       green_edge_o,
  input wire logic [sem_pkg::CH_W-1:0]       blue_edge_o,
  input wire logic                           frame_last_o,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // A stalled result word keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_edge_o) &&
      $stable(green_edge_o) && $stable(blue_edge_o) && $stable(frame_last_o))
    else $error("result word changed while stalled");

  // A new result is only loaded while the block is busy with a word.
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the block was idle");

  // The handshake outputs are always known once out of reset.
  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o, cfg_ready_o}))
    else $error("handshake output is unknown");

  // An accepted word never turns into a result at the next edge.
  a_in_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after an input word");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
`timescale 1ns / 1ps

module tb;
  import sem_pkg::*;

  // Busy time of one result-producing word plus margin, taken before register writes.
  localparam int SETTLE_CYCLES = 20;
  // Receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_WORDS  = 1800;
  // Pixels sent into the widest frame: one full row and a few more.
  localparam int WIDE_PIXELS   = MAX_WIDTH + 6;
  // Smallest sum of squares whose rounded root no longer fits a channel.
  localparam int MAG_SATURATES_AT = CH_MAX_INT * CH_MAX_INT + CH_MAX_INT + 1;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = CFG_IDX_W'(REG_FRAME_HEIGHT + 1);
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LAST  = '1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } edge_t;

  typedef enum {ROW_CFG, ROW_WORD} row_kind_e;
  typedef enum {PIX_ANY, PIX_EXTREME, PIX_FAINT} pix_style_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  mode;
    pix_t                  pix;
    bit                    typed;
    bit                    has_res;
    edge_t                 res;
  } row_t;

  // A lone pixel has no neighbors, so both gradients are zero.
  localparam edge_t LONE_PIXEL = '{red: '0, green: '0, blue: '0, last: 1'b1};
  localparam edge_t NO_EDGE    = '0;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  mode_i      = MODE_PIXEL;
  logic [CH_W-1:0]       red_in_i    = '0;
  logic [CH_W-1:0]       green_in_i  = '0;
  logic [CH_W-1:0]       blue_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CH_W-1:0]       red_edge_o;
  logic [CH_W-1:0]       green_edge_o;
  logic [CH_W-1:0]       blue_edge_o;
  logic                  frame_last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  sobel_edge_magnitude_rgb DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_edge_o   (red_edge_o),
    .green_edge_o (green_edge_o),
    .blue_edge_o  (blue_edge_o),
    .frame_last_o (frame_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shared run state.
  edge_t pending_edges[$];
  row_t  stim_rows[$];
  int    errors     = 0;
  int    rnd_words  = 0;
  bit    steady     = 1'b0;
  int    hold_asked = 0;

  // Predictor state: frame geometry, raster counters, line stores and window.
  int   cfg_width  = 1;
  int   cfg_height = 1;
  int   in_col, in_row, out_col, out_row;
  pix_t row_minus1 [MAX_WIDTH];
  pix_t row_minus2 [MAX_WIDTH];
  pix_t win [9];

  function automatic void frame_restart();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    foreach (win[k]) win[k] = '0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    int v;
    if (idx == REG_FRAME_WIDTH) begin
      v = data[FRAME_WIDTH_W-1:0];
      cfg_width = (v == 0) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
      frame_restart();
    end else if (idx == REG_FRAME_HEIGHT) begin
      v = data;
      cfg_height = (v == 0) ? 1 : v;
      frame_restart();
    end
  endfunction

  // Rounded, saturated gradient magnitude of one channel of a 3x3 window.
  function automatic logic [CH_W-1:0] channel_magnitude(input pix_t w [9], input int shift);
    int p [9];
    int gx, gy, s, root;
    for (int k = 0; k < 9; k++) p[k] = (w[k] >> shift) & CH_MAX_INT;
    gx = p[2] + 2 * p[5] + p[8] - p[0] - 2 * p[3] - p[6];
    gy = p[6] + 2 * p[7] + p[8] - p[0] - 2 * p[1] - p[2];
    s  = gx * gx + gy * gy;
    if (s >= MAG_SATURATES_AT) return CH_MAX;
    root = 0;
    while ((root + 1) * (root + 1) <= s) root++;
    // Round half up: sqrt(s) >= root + 0.5 exactly when s - root^2 > root.
    if (s - root * root > root) root++;
    return CH_W'(root);
  endfunction

  // Advances the predictor by one accepted word; returns 1 if it yields a result.
  function automatic bit predict_edges(input logic m, input pix_t p, output edge_t res);
    bit   draining;
    int   col, pr, pc;
    pix_t top, mid, bot;
    pix_t calc [9];
    res = NO_EDGE;
    draining = (in_row >= cfg_height);
    // Flush words during the frame and pixels during the drain are dropped.
    if (draining != (m == MODE_FLUSH)) return 1'b0;
    col = in_col;
    bot = draining ? '0 : p;
    mid = (in_row >= 1 && in_row - 1 < cfg_height) ? row_minus1[col] : '0;
    top = (in_row >= 2 && in_row - 2 < cfg_height) ? row_minus2[col] : '0;
    // At column zero the previous row is finished with a zero right column.
    for (int r = 0; r < 3; r++) begin
      if (in_col == 0) begin
        calc[3*r]     = win[3*r+1];
        calc[3*r+1]   = win[3*r+2];
        calc[3*r+2]   = '0;
        win[3*r]      = '0;
        win[3*r+1]    = '0;
      end else begin
        win[3*r]      = win[3*r+1];
        win[3*r+1]    = win[3*r+2];
      end
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bot;
    if (in_col != 0) calc = win;
    if (!draining) begin
      row_minus2[col] = row_minus1[col];
      row_minus1[col] = p;
    end
    in_col++;
    if (in_col >= cfg_width) begin
      in_col = 0;
      in_row++;
    end
    // The output trails the position just taken by one row and one pixel.
    pr = in_row;
    pc = in_col;
    if (pc == 0) begin
      pr--;
      pc = cfg_width - 1;
    end else begin
      pc--;
    end
    if (!(pr >= 2 || (pr == 1 && pc >= 1))) return 1'b0;
    res.red   = channel_magnitude(calc, 2 * CH_W);
    res.green = channel_magnitude(calc, CH_W);
    res.blue  = channel_magnitude(calc, 0);
    res.last  = (out_row == cfg_height - 1 && out_col == cfg_width - 1);
    if (res.last) begin
      frame_restart();
    end else begin
      out_col++;
      if (out_col >= cfg_width) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic pix_t random_pixel(input pix_style_e style);
    pix_t p;
    p = pix_t'($urandom);
    if (style == PIX_EXTREME) begin
      for (int c = 0; c < NUM_CH; c++) p[c*CH_W +: CH_W] = $urandom_range(1) ? CH_MAX : '0;
    end else if (style == PIX_FAINT) begin
      p = p & 24'h0F0F0F;
    end
    return p;
  endfunction

  // Drops valid and waits until every expected result has arrived.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_edges.size() != 0);
  endtask

  // Lets the block finish any word that yields no result before going on.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    apply_register(idx, data);
  endtask

  // Offers one word, with random gaps unless steady, and predicts on acceptance.
  task automatic send_word(input logic m, input pix_t p, output bit got, output edge_t res);
    if (!steady) begin
      while ($urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    red_in_i   <= p[2*CH_W +: CH_W];
    green_in_i <= p[CH_W +: CH_W];
    blue_in_i  <= p[0 +: CH_W];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = predict_edges(m, p, res);
  endtask

  task automatic offer(input logic m, input pix_t p);
    bit    got;
    edge_t res;
    send_word(m, p, got, res);
    if (got) pending_edges.push_back(res);
  endtask

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, mode: MODE_PIXEL, pix: '0,
            typed: 1'b0, has_res: 1'b0, res: NO_EDGE};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_word(input logic m, input pix_t p, input bit typed,
                                   input bit has_res, input edge_t res);
    row_t row;
    row = '{kind: ROW_WORD, idx: '0, data: '0, mode: m, pix: p,
            typed: typed, has_res: has_res, res: res};
    stim_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    // Reset leaves a 1x1 frame: a stray flush, the pixel, two drain flushes with a stray pixel between.
    add_word(MODE_FLUSH, 24'h123456, 1'b1, 1'b0, NO_EDGE);
    add_word(MODE_PIXEL, 24'hFFFFFF, 1'b1, 1'b0, NO_EDGE);
    add_word(MODE_FLUSH, 24'h000000, 1'b1, 1'b0, NO_EDGE);
    add_word(MODE_PIXEL, 24'hA5A5A5, 1'b1, 1'b0, NO_EDGE);
    add_word(MODE_FLUSH, 24'hFFFFFF, 1'b1, 1'b1, LONE_PIXEL);
    // 3x2 frame; the width write carries high bits that the register drops.
    add_cfg(REG_FRAME_WIDTH, 16'hF803);
    add_cfg(REG_FRAME_HEIGHT, 16'd2);
    add_word(MODE_PIXEL, 24'h000000, 1'b0, 1'b0, NO_EDGE);
    add_word(MODE_PIXEL, 24'hFFFFFF, 1'b0, 1'b0, NO_EDGE);
    add_word(MODE_PIXEL, 24'h00FF00, 1'b0, 1'b0, NO_EDGE);
    add_word(MODE_PIXEL, 24'hFF00FF, 1'b0, 1'b0, NO_EDGE);
    add_word(MODE_PIXEL, 24'h0000FF, 1'b0, 1'b0, NO_EDGE);
    add_word(MODE_PIXEL, 24'h7F7F7F, 1'b0, 1'b0, NO_EDGE);
    for (int i = 0; i < 4; i++) add_word(MODE_FLUSH, 24'h000000, 1'b0, 1'b0, NO_EDGE);
    // Zero width and height read as one; writes to unknown indexes change nothing.
    add_cfg(REG_FRAME_WIDTH, 16'd0);
    add_cfg(REG_FRAME_HEIGHT, 16'd0);
    add_cfg(REG_NONE_LAST, 16'd5);
    add_cfg(REG_NONE_FIRST, 16'hFFFF);
    add_word(MODE_PIXEL, 24'h808080, 1'b1, 1'b0, NO_EDGE);
    add_word(MODE_FLUSH, 24'h000000, 1'b1, 1'b0, NO_EDGE);
    add_word(MODE_FLUSH, 24'h000000, 1'b1, 1'b1, LONE_PIXEL);
  endfunction

  // One random setting followed by one or two frames, some cut short, with noise words.
  task automatic random_phase(input int phase);
    int                    w, h, frames, n;
    bit                    cut;
    pix_style_e            style;
    logic [CFG_DATA_W-1:0] wdata;
    w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    h = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
    if (phase == 1) begin
      w = 8;
      h = 8;
    end
    wdata = (CFG_DATA_W'($urandom) & 16'hF800) | CFG_DATA_W'(w);
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_IDX_W'(REG_NONE_FIRST + $urandom_range(REG_NONE_LAST - REG_NONE_FIRST)),
                CFG_DATA_W'($urandom));
    end
    if ($urandom_range(1)) begin
      write_reg(REG_FRAME_WIDTH, wdata);
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    end else begin
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
      write_reg(REG_FRAME_WIDTH, wdata);
    end
    steady = (phase >= 3 && phase <= 6);
    if (phase == 1) hold_asked++;
    frames = $urandom_range(2, 1);
    for (int f = 0; f < frames; f++) begin
      style = pix_style_e'($urandom_range(2));
      cut   = ($urandom_range(5) == 0);
      n     = cut ? $urandom_range(w * h, 1) : w * h;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0) offer(MODE_FLUSH, random_pixel(PIX_ANY));
        offer(MODE_PIXEL, random_pixel(style));
        rnd_words++;
        // In phase 2, hold the sender mid-frame until every result is out.
        if (phase == 2 && i == n / 2) wait_results();
      end
      if (cut) break;
      for (int i = 0; i <= w; i++) begin
        if ($urandom_range(19) == 0) offer(MODE_PIXEL, random_pixel(PIX_ANY));
        offer(MODE_FLUSH, random_pixel(PIX_ANY));
        rnd_words++;
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, a stall-free stretch, and one long hold-off on request.
  initial begin : receiver
    int hold_left;
    int hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk_i);
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    edge_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_edges.size() == 0) begin
        $error("result word with nothing expected: %0d %0d %0d last %0d",
               red_edge_o, green_edge_o, blue_edge_o, frame_last_o);
        errors++;
      end else begin
        want = pending_edges.pop_front();
        check_field("red_edge", want.red, red_edge_o);
        check_field("green_edge", want.green, green_edge_o);
        check_field("blue_edge", want.blue, blue_edge_o);
        check_field("frame_last", want.last, frame_last_o);
      end
    end
  end

  initial begin : stimulus
    row_t  row;
    bit    got;
    edge_t res;
    int    phase;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_minus1[i] = '0;
      row_minus2[i] = '0;
    end
    frame_restart();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: typed expectations where obvious, predictor elsewhere.
    build_directed();
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.data);
      end else begin
        send_word(row.mode, row.pix, got, res);
        if (row.typed) begin
          got = row.has_res;
          res = row.res;
        end
        if (got) pending_edges.push_back(res);
      end
    end

    // Widest rows: width clamps to the maximum, height at its top; one row and a bit.
    write_reg(REG_FRAME_WIDTH, 16'hFFFF);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    for (int i = 0; i < WIDE_PIXELS; i++) begin
      offer(MODE_PIXEL, random_pixel(pix_style_e'($urandom_range(2))));
      rnd_words++;
    end

    phase = 0;
    while (rnd_words < RANDOM_WORDS) begin
      random_phase(phase);
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("[sobel_edge_magnitude_rgb] OK");
    end else begin
      $display("[sobel_edge_magnitude_rgb] ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("[sobel_edge_magnitude_rgb] ERROR");
    $finish;
  end

endmodule

>>> sobel_edge_magnitude_rgb.f
sv/sem_pkg.sv
sv/sem_line_ram.sv
sv/sem_mag.sv
sv/sobel_edge_magnitude_rgb.sv
sv/sem_checker.sv
tb/tb.sv
